[hw/rtl/nccf_pkg.sv]
// Shared types, constants and helpers for the nearest-centroid classifier.
`timescale 1ns / 1ps
package nccf_pkg;

    localparam int COORD_W   = 12;
    localparam int CENTER_W  = 3 * COORD_W;
    localparam int DIST_W    = 26;
    localparam int SQ_W      = 2 * COORD_W;
    localparam int LABEL_W   = 3;
    localparam int IDX_W     = 4;
    localparam int CMD_W     = 2;
    localparam int NUM_REGS  = 6;
    localparam int CFG_IDX_W = 3;
    localparam int WINNER_W  = 3;
    localparam int COUNT_W   = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLASSIFY = 2'd0,
        CMD_CLEAR    = 2'd1,
        CMD_READ     = 2'd2
    } cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic [LABEL_W-1:0] label;
        logic [LABEL_W-1:0] row;
        logic [DIST_W-1:0]  best_dist;
        logic [IDX_W-1:0]   best_idx;
    } item_t;

    localparam logic [CENTER_W-1:0] CENTER_RESET [NUM_REGS] = '{
        36'd30238668250, 36'd20256200192, 36'd25441515099,
        36'd25120466304, 36'd25356056332, 36'd25172333786
    };

    function automatic logic [CENTER_W-1:0] center_init(input int k);
        logic [CENTER_W-1:0] v;
        v = '0;
        for (int i = 0; i < NUM_REGS; i++)
        begin
            if (i == k)
            begin
                v = CENTER_RESET[i];
            end
        end
        return v;
    endfunction

    function automatic logic [COORD_W-1:0] abs_diff(
        input logic [COORD_W-1:0] a,
        input logic [COORD_W-1:0] b
    );
        return (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

[hw/rtl/nccf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module nccf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 36,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/nccf_cell.sv]
// One centroid cell: holds a centroid, measures the distance and keeps the running best.
`timescale 1ns / 1ps
module nccf_cell
    import nccf_pkg::*;
#(
    parameter int CELL_IDX = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CENTER_W-1:0]  cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  item_t                in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output item_t                out_item
);

    localparam bit WRITABLE = (CELL_IDX < NUM_REGS);
    localparam bit FIRST    = (CELL_IDX == 0);
    localparam logic [CENTER_W-1:0] INIT = center_init(CELL_IDX);
    localparam logic [CFG_IDX_W-1:0] MY_INDEX = CFG_IDX_W'(CELL_IDX);

    logic [CENTER_W-1:0] center_reg;
    logic                a_valid_reg;
    item_t               a_item_reg;
    logic [SQ_W-1:0]     sq_x_reg, sq_y_reg, sq_z_reg;
    logic                b_valid_reg;
    item_t               b_item_reg;

    logic                a_en, b_en;
    logic [COORD_W-1:0]  dx, dy, dz;
    logic [DIST_W-1:0]   sum_dist;
    item_t               b_item_next;

    assign b_en     = !b_valid_reg || out_ready;
    assign a_en     = !a_valid_reg || b_en;
    assign in_ready = a_en;

    assign dx = abs_diff(in_item.x, center_reg[3*COORD_W-1:2*COORD_W]);
    assign dy = abs_diff(in_item.y, center_reg[2*COORD_W-1:COORD_W]);
    assign dz = abs_diff(in_item.z, center_reg[COORD_W-1:0]);

    assign sum_dist = DIST_W'(sq_x_reg) + DIST_W'(sq_y_reg) + DIST_W'(sq_z_reg);

    always_comb
    begin
        b_item_next = a_item_reg;
        // strict less-than keeps the lowest index on ties
        if (FIRST || (sum_dist < a_item_reg.best_dist))
        begin
            b_item_next.best_dist = sum_dist;
            b_item_next.best_idx  = IDX_W'(CELL_IDX);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_reg  <= INIT;
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (WRITABLE && cfg_we && (cfg_index == MY_INDEX))
            begin
                center_reg <= cfg_data;
            end
            if (a_en)
            begin
                a_valid_reg <= in_valid;
            end
            if (b_en)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_en && in_valid)
        begin
            a_item_reg <= in_item;
            sq_x_reg   <= dx * dx;
            sq_y_reg   <= dy * dy;
            sq_z_reg   <= dz * dz;
        end
        if (b_en && a_valid_reg)
        begin
            b_item_reg <= b_item_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_item  = b_item_reg;

endmodule

[hw/rtl/nccf_matrix.sv]
// Confusion matrix stage: read-modify-write of one cell, clear, read, and result register.
`timescale 1ns / 1ps
module nccf_matrix
    import nccf_pkg::*;
#(
    parameter int NUM_CENTERS = 6,
    parameter int COUNT_BITS  = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  item_t               in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [WINNER_W-1:0] winner,
    output logic [DIST_W-1:0]   min_dist,
    output logic [COUNT_W-1:0]  count
);

    localparam int DEPTH  = NUM_CENTERS * NUM_CENTERS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NC_W   = IDX_W + 1;
    localparam logic [NC_W-1:0] NC = NC_W'(NUM_CENTERS);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    logic                  p_valid_reg;
    item_t                 p_item_reg;
    logic [ADDR_W-1:0]     p_addr_reg;
    logic                  p_hit_reg;

    logic                  o_valid_reg;
    logic [WINNER_W-1:0]   o_winner_reg;
    logic [DIST_W-1:0]     o_dist_reg;
    logic [COUNT_BITS-1:0] o_count_reg;

    logic [DEPTH-1:0]      ent_valid_reg;
    logic                  byp_valid_reg;
    logic [ADDR_W-1:0]     byp_addr_reg;
    logic [COUNT_BITS-1:0] byp_data_reg;

    logic                  p_en, o_en;
    logic [NC_W-1:0]       sel_row, sel_col;
    logic [2*NC_W-1:0]     addr_wide;
    logic                  hit;
    logic [COUNT_BITS-1:0] rdata, old_val, inc_val;
    logic                  wr_now, clr_now;
    logic [WINNER_W-1:0]   o_winner_next;
    logic [DIST_W-1:0]     o_dist_next;
    logic [COUNT_BITS-1:0] o_count_next;

    assign o_en     = !o_valid_reg || out_ready;
    assign p_en     = !p_valid_reg || o_en;
    assign in_ready = p_en;

    // read selects the row from the command, classify from the winner
    always_comb
    begin
        sel_col = NC_W'(in_item.label);
        if (in_item.cmd == CMD_READ)
        begin
            sel_row = NC_W'(in_item.row);
        end
        else
        begin
            sel_row = NC_W'(in_item.best_idx);
        end
        hit       = (sel_row < NC) && (sel_col < NC);
        addr_wide = sel_row * NC + sel_col;
    end

    nccf_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (wr_now),
        .waddr (p_addr_reg),
        .wdata (inc_val),
        .re    (p_en),
        .raddr (addr_wide[ADDR_W-1:0]),
        .rdata (rdata)
    );

    // the last write may land on the edge of this read: take it from the bypass
    always_comb
    begin
        old_val = '0;
        if (p_hit_reg)
        begin
            if (byp_valid_reg && (byp_addr_reg == p_addr_reg))
            begin
                old_val = byp_data_reg;
            end
            else if (ent_valid_reg[p_addr_reg])
            begin
                old_val = rdata;
            end
        end
        inc_val = (old_val == COUNT_MAX) ? old_val : old_val + 1'b1;
    end

    always_comb
    begin
        o_winner_next = '0;
        o_dist_next   = '0;
        o_count_next  = '0;
        wr_now        = 1'b0;
        clr_now       = 1'b0;
        case (p_item_reg.cmd)
            CMD_CLASSIFY:
            begin
                o_winner_next = WINNER_W'(p_item_reg.best_idx);
                o_dist_next   = p_item_reg.best_dist;
                if (p_hit_reg)
                begin
                    o_count_next = inc_val;
                    wr_now       = o_en && p_valid_reg;
                end
            end
            CMD_CLEAR:
            begin
                clr_now = o_en && p_valid_reg;
            end
            CMD_READ:
            begin
                o_count_next = old_val;
            end
            default:
            begin
                o_count_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg   <= 1'b0;
            o_valid_reg   <= 1'b0;
            ent_valid_reg <= '0;
            byp_valid_reg <= 1'b0;
        end
        else
        begin
            if (p_en)
            begin
                p_valid_reg <= in_valid;
            end
            if (o_en)
            begin
                o_valid_reg <= p_valid_reg;
            end
            if (clr_now)
            begin
                ent_valid_reg <= '0;
                byp_valid_reg <= 1'b0;
            end
            else if (wr_now)
            begin
                ent_valid_reg[p_addr_reg] <= 1'b1;
                byp_valid_reg             <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (p_en && in_valid)
        begin
            p_item_reg <= in_item;
            p_addr_reg <= addr_wide[ADDR_W-1:0];
            p_hit_reg  <= hit;
        end
        if (o_en && p_valid_reg)
        begin
            o_winner_reg <= o_winner_next;
            o_dist_reg   <= o_dist_next;
            o_count_reg  <= o_count_next;
        end
        if (wr_now)
        begin
            byp_addr_reg <= p_addr_reg;
            byp_data_reg <= inc_val;
        end
    end

    assign out_valid = o_valid_reg;
    assign winner    = o_winner_reg;
    assign min_dist  = o_dist_reg;
    assign count     = COUNT_W'(o_count_reg);

endmodule

[hw/rtl/nearest_centroid_confusion_core.sv]
// Throughput: one item per cycle unless the output is held; each centroid cell is two register
// stages, one squares and one sums and compares, and the matrix read-modify-write is forwarded
// cycle to cycle. Stages hand over independently, so bubbles close up while the output is held.
// Reset: centroids load their default values and the confusion matrix reads as all zero.
`timescale 1ns / 1ps
module nearest_centroid_confusion_core
    import nccf_pkg::*;
#(
    parameter int NUM_CENTERS = 6,
    parameter int COUNT_BITS  = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CENTER_W-1:0]  cfg_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // sample_x[11:0], sample_y[23:12], sample_z[35:24], true_class[38:36],
    // read_row[41:39], zero fill [47:42]
    input  logic [47:0]          s_tdata,
    // cmd[1:0]
    input  logic [1:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // winner[2:0], min_dist[28:3], count[44:29], zero fill [47:45]
    output logic [47:0]          m_tdata
);

    logic                link_valid [NUM_CENTERS+1];
    logic                link_ready [NUM_CENTERS+1];
    item_t               link_item  [NUM_CENTERS+1];

    logic [WINNER_W-1:0] winner;
    logic [DIST_W-1:0]   min_dist;
    logic [COUNT_W-1:0]  count;

    always_comb
    begin
        link_item[0].cmd       = s_tuser;
        link_item[0].x         = s_tdata[11:0];
        link_item[0].y         = s_tdata[23:12];
        link_item[0].z         = s_tdata[35:24];
        link_item[0].label     = s_tdata[38:36];
        link_item[0].row       = s_tdata[41:39];
        link_item[0].best_dist = '0;
        link_item[0].best_idx  = '0;
    end

    assign link_valid[0] = s_tvalid;
    assign s_tready      = link_ready[0];

    for (genvar k = 0; k < NUM_CENTERS; k++)
    begin : g_cell
        nccf_cell #(
            .CELL_IDX (k)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cfg_we    (cfg_we),
            .cfg_index (cfg_index),
            .cfg_data  (cfg_data),
            .in_valid  (link_valid[k]),
            .in_ready  (link_ready[k]),
            .in_item   (link_item[k]),
            .out_valid (link_valid[k+1]),
            .out_ready (link_ready[k+1]),
            .out_item  (link_item[k+1])
        );
    end

    nccf_matrix #(
        .NUM_CENTERS (NUM_CENTERS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_matrix (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (link_valid[NUM_CENTERS]),
        .in_ready  (link_ready[NUM_CENTERS]),
        .in_item   (link_item[NUM_CENTERS]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .winner    (winner),
        .min_dist  (min_dist),
        .count     (count)
    );

    assign m_tdata = {3'b000, count, min_dist, winner};

endmodule
